/* hw/rtl/mhrb_pkg.sv */
package mhrb_pkg;

	localparam int MAX_LEN_LOG2_DEF = 10;
	localparam int ITEM_BITS_DEF    = 32;
	localparam int COUNT_BITS       = 64;
	localparam int CFG_BITS         = 4;
	localparam int ACTION_BITS      = 3;

	localparam logic [CFG_BITS-1:0] LEN_LOG2_RESET = 4'd10;

	typedef enum logic [ACTION_BITS-1:0] {
		ACT_INSERT = 3'd0,
		ACT_READ   = 3'd1,
		ACT_C2P    = 3'd2,
		ACT_P2C    = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

endpackage

/* hw/rtl/mirrored_history_ring_buffer.sv */
// History buffer of 2^length_log2 items (length_log2 capped at MAX_LEN_LOG2), double mapped
// in one single-port RAM of 2^(MAX_LEN_LOG2+1) entries so the newest items form one window.
// Count and position conversions and clear go straight back to idle; an insert passes through
// ST_WRITE_B, since both mirror slots are written through the one RAM port; a window read
// passes through ST_READ, for the registered RAM read. The result sits in an output register,
// and a new input transaction is taken in the cycle that the pending result is taken. There is
// no clearing pass after reset: the RAM contents stay undefined until written. cfg_data is to be
// written only while the block is idle; the block does not enforce it. cfg_ready is always high.
module mirrored_history_ring_buffer #(
	parameter int MAX_LEN_LOG2 = mhrb_pkg::MAX_LEN_LOG2_DEF,
	parameter int ITEM_BITS    = mhrb_pkg::ITEM_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [mhrb_pkg::CFG_BITS-1:0]    cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [mhrb_pkg::ACTION_BITS-1:0] action,
	input  logic [ITEM_BITS-1:0]             item_in,
	input  logic [MAX_LEN_LOG2-1:0]          window_pos,
	input  logic [mhrb_pkg::COUNT_BITS-1:0]  query_count,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [ITEM_BITS-1:0]             item_out,
	output logic [MAX_LEN_LOG2:0]            window_length,
	output logic [mhrb_pkg::COUNT_BITS-1:0]  total_count,
	output logic [MAX_LEN_LOG2-1:0]          pos_out,
	output logic [mhrb_pkg::COUNT_BITS-1:0]  count_out,
	output logic                             range_error
);

	localparam int M      = MAX_LEN_LOG2;
	localparam int CW     = mhrb_pkg::COUNT_BITS;
	localparam int LG_W   = $clog2(MAX_LEN_LOG2 + 1);
	localparam int DEPTH  = 2 << MAX_LEN_LOG2;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_WRITE_B = 3'b010,
		ST_READ    = 3'b100
	} state_t;

	state_t state_q;

	logic [mhrb_pkg::CFG_BITS-1:0] len_log2_q;
	logic [M-1:0]                  wp_q;
	logic [CW-1:0]                 cnt_q;
	logic                          out_valid_q;

	logic [M:0]           b_addr_q;
	logic [ITEM_BITS-1:0] wdata_q;
	logic                 item_sel_q;
	logic [M:0]           window_length_q;
	logic [CW-1:0]        total_count_q;
	logic [M-1:0]         pos_out_q;
	logic [CW-1:0]        count_out_q;
	logic                 range_error_q;

	logic                 accept;
	logic                 out_set;
	mhrb_pkg::action_t    act;
	logic [LG_W-1:0]      lg;
	logic [M:0]           len;
	logic [M:0]           len_m1;
	logic [M-1:0]         mask;
	logic [M-1:0]         a_addr;
	logic [M:0]           b_addr;
	logic [M-1:0]         wp_next;
	logic [CW-1:0]        cnt_new;
	logic [M:0]           n;
	logic [M-1:0]         wp_prev;
	logic [M:0]           stop;
	logic [M:0]           start;
	logic [M:0]           slot;
	logic                 pos_err;
	logic [CW:0]          sub;
	logic                 c2p_err;
	logic [M:0]           c2p_pos;
	logic [M:0]           p2c_diff;

	logic                 nxt_err;
	logic [M-1:0]         nxt_pos;
	logic [CW-1:0]        nxt_count;
	logic                 nxt_read;

	logic                 ram_en;
	logic                 ram_we;
	logic [M:0]           ram_addr;
	logic [ITEM_BITS-1:0] ram_wdata;
	logic [ITEM_BITS-1:0] ram_rdata;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign accept    = in_valid && in_ready;
	assign act       = mhrb_pkg::action_t'(action);

	assign lg      = (int'(len_log2_q) > MAX_LEN_LOG2) ? LG_W'(MAX_LEN_LOG2) : LG_W'(len_log2_q);
	assign len     = (M + 1)'(1) << lg;
	assign len_m1  = len - (M + 1)'(1);
	assign mask    = len_m1[M-1:0];
	assign a_addr  = wp_q & mask;
	assign b_addr  = {1'b0, a_addr} + len;
	assign wp_next = (a_addr + M'(1)) & mask;

	always_comb begin
		cnt_new = cnt_q;
		if (act == mhrb_pkg::ACT_INSERT) begin
			cnt_new = cnt_q + CW'(1);
		end else if (act == mhrb_pkg::ACT_CLEAR) begin
			cnt_new = '0;
		end
	end

	// held items: min(count, length)
	assign n = ((cnt_new[CW-1:M+1] == '0) && (cnt_new[M:0] < len)) ? cnt_new[M:0] : len;

	assign wp_prev  = (wp_q - M'(1)) & mask;
	assign stop     = {1'b0, wp_prev} + len;
	assign start    = stop - n + (M + 1)'(1);
	assign slot     = start + {1'b0, window_pos};
	assign pos_err  = {1'b0, window_pos} >= n;

	// borrow flags a query count beyond the insert count
	assign sub      = {1'b0, cnt_q} - {1'b0, query_count};
	assign c2p_err  = sub[CW] || !((sub[CW-1:M+1] == '0) && (sub[M:0] < n));
	assign c2p_pos  = n - sub[M:0] - (M + 1)'(1);
	assign p2c_diff = n - (M + 1)'(1) - {1'b0, window_pos};

	always_comb begin
		nxt_err   = 1'b0;
		nxt_pos   = '0;
		nxt_count = '0;
		nxt_read  = 1'b0;
		unique case (act)
			mhrb_pkg::ACT_INSERT, mhrb_pkg::ACT_CLEAR: begin
			end
			mhrb_pkg::ACT_READ: begin
				nxt_err  = pos_err;
				nxt_read = !pos_err;
			end
			mhrb_pkg::ACT_C2P: begin
				nxt_err = c2p_err;
				nxt_pos = c2p_err ? '0 : c2p_pos[M-1:0];
			end
			mhrb_pkg::ACT_P2C: begin
				nxt_err   = pos_err;
				nxt_count = pos_err ? '0 : (cnt_q - CW'(p2c_diff));
			end
			default: begin
			end
		endcase
	end

	// a result becomes valid right after a non-read transaction or after the read cycle
	assign out_set = (accept && !nxt_read) || (state_q == ST_READ);

	always_comb begin
		ram_en    = 1'b0;
		ram_we    = 1'b0;
		ram_addr  = slot;
		ram_wdata = item_in;
		if (state_q == ST_WRITE_B) begin
			ram_en    = 1'b1;
			ram_we    = 1'b1;
			ram_addr  = b_addr_q;
			ram_wdata = wdata_q;
		end else if (accept && act == mhrb_pkg::ACT_INSERT) begin
			ram_en   = 1'b1;
			ram_we   = 1'b1;
			ram_addr = {1'b0, a_addr};
		end else if (accept && nxt_read) begin
			ram_en = 1'b1;
		end
	end

	mhrb_ram #(
		.WIDTH(ITEM_BITS),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.en   (ram_en),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_log2_q  <= mhrb_pkg::LEN_LOG2_RESET;
			wp_q        <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				len_log2_q <= cfg_data;
			end
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cnt_q <= cnt_new;
						if (act == mhrb_pkg::ACT_INSERT) begin
							wp_q    <= wp_next;
							state_q <= ST_WRITE_B;
						end else if (act == mhrb_pkg::ACT_CLEAR) begin
							wp_q <= '0;
						end
						if (nxt_read) begin
							state_q <= ST_READ;
						end
					end
				end
				ST_WRITE_B: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			b_addr_q        <= b_addr;
			wdata_q         <= item_in;
			item_sel_q      <= nxt_read;
			window_length_q <= n;
			total_count_q   <= cnt_new;
			pos_out_q       <= nxt_pos;
			count_out_q     <= nxt_count;
			range_error_q   <= nxt_err;
		end
	end

	// read data holds until the next read, which waits for this result to be taken
	assign out_valid     = out_valid_q;
	assign item_out      = item_sel_q ? ram_rdata : '0;
	assign window_length = window_length_q;
	assign total_count   = total_count_q;
	assign pos_out       = pos_out_q;
	assign count_out     = count_out_q;
	assign range_error   = range_error_q;

endmodule

/* hw/rtl/mhrb_ram.sv */
module mhrb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

/* hw/rtl/mhrb_checker.sv */
module mhrb_checker #(
	parameter int MAX_LEN_LOG2 = mhrb_pkg::MAX_LEN_LOG2_DEF,
	parameter int ITEM_BITS    = mhrb_pkg::ITEM_BITS_DEF
) (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [ITEM_BITS-1:0]            item_out,
	input logic [MAX_LEN_LOG2:0]           window_length,
	input logic [mhrb_pkg::COUNT_BITS-1:0] total_count,
	input logic [MAX_LEN_LOG2-1:0]         pos_out,
	input logic [mhrb_pkg::COUNT_BITS-1:0] count_out,
	input logic                            range_error
);

	localparam logic [MAX_LEN_LOG2:0] MAX_LEN = (MAX_LEN_LOG2 + 1)'(1) << MAX_LEN_LOG2;

	// an out of range query reports no item, position or count beside the error
	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_error |-> item_out == '0 && pos_out == '0 && count_out == '0)
		else $error("range error result carries data");

	// the window never holds more than the inserted items or the built length
	a_window_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window_length <= MAX_LEN &&
			mhrb_pkg::COUNT_BITS'(window_length) <= total_count)
		else $error("window length out of bounds");

	// a found position lies inside the window
	a_pos_inside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pos_out != '0 |-> !range_error && {1'b0, pos_out} < window_length)
		else $error("position outside window");

	// a stalled result transaction holds its total count, window length and item
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(total_count) &&
			$stable(window_length) && $stable(item_out))
		else $error("result changed while stalled");

endmodule

bind mirrored_history_ring_buffer mhrb_checker #(
	.MAX_LEN_LOG2(MAX_LEN_LOG2),
	.ITEM_BITS   (ITEM_BITS)
) u_mhrb_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.item_out     (item_out),
	.window_length(window_length),
	.total_count  (total_count),
	.pos_out      (pos_out),
	.count_out    (count_out),
	.range_error  (range_error)
);

/* tb/sv/mirrored_history_ring_buffer_tb.sv */
module mirrored_history_ring_buffer_tb;

	localparam int MAX_LG = mhrb_pkg::MAX_LEN_LOG2_DEF;
	localparam int IB = mhrb_pkg::ITEM_BITS_DEF;
	localparam int ACTION_BITS = mhrb_pkg::ACTION_BITS;
	localparam int COUNT_BITS = mhrb_pkg::COUNT_BITS;
	localparam int CFG_BITS = mhrb_pkg::CFG_BITS;
	localparam logic [CFG_BITS-1:0] LEN_LOG2_RESET = mhrb_pkg::LEN_LOG2_RESET;
	localparam int STORE_DEPTH = 2 << MAX_LG;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_PHASES = 9;
	localparam int PHASE_ITEMS = 95;

	typedef struct packed {
		logic [ACTION_BITS-1:0] act;
		logic [IB-1:0]          data;
		logic [MAX_LG-1:0]      wpos;
		logic [COUNT_BITS-1:0]  qcnt;
	} request_t;

	typedef struct packed {
		logic [IB-1:0]         item;
		logic [MAX_LG:0]       wlen;
		logic [COUNT_BITS-1:0] total;
		logic [MAX_LG-1:0]     pos;
		logic [COUNT_BITS-1:0] cnt;
		logic                  err;
	} reply_t;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_BITS-1:0]    cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic [ACTION_BITS-1:0] action;
	logic [IB-1:0]          item_in;
	logic [MAX_LG-1:0]      window_pos;
	logic [COUNT_BITS-1:0]  query_count;
	logic                   out_valid;
	logic                   out_ready;
	logic [IB-1:0]          item_out;
	logic [MAX_LG:0]        window_length;
	logic [COUNT_BITS-1:0]  total_count;
	logic [MAX_LG-1:0]      pos_out;
	logic [COUNT_BITS-1:0]  count_out;
	logic                   range_error;

	// shadow copy of the buffer
	logic [IB-1:0]         hist_mem [STORE_DEPTH];
	bit                    hist_written [STORE_DEPTH];
	int unsigned           wr_pos = 0;
	logic [COUNT_BITS-1:0] ins_cnt = '0;
	logic [CFG_BITS-1:0]   len_log2 = LEN_LOG2_RESET;

	reply_t answers_due [$];
	reply_t want_reply;
	reply_t got_reply;
	int     fault_count = 0;
	int     hold_req = 0;
	bit     no_idle = 0;
	int     idle_cycles;

	mirrored_history_ring_buffer #(
		.MAX_LEN_LOG2(MAX_LG),
		.ITEM_BITS(IB)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.item_in(item_in),
		.window_pos(window_pos),
		.query_count(query_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.item_out(item_out),
		.window_length(window_length),
		.total_count(total_count),
		.pos_out(pos_out),
		.count_out(count_out),
		.range_error(range_error)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int unsigned cur_len();
		return 1 << ((len_log2 > MAX_LG) ? MAX_LG : len_log2);
	endfunction

	function automatic int unsigned held_items();
		int unsigned len;
		len = cur_len();
		return (ins_cnt < len) ? int'(ins_cnt) : len;
	endfunction

	function automatic int unsigned window_slot(int unsigned wpos);
		int unsigned len, stop;
		len = cur_len();
		stop = ((wr_pos - 1) & (len - 1)) + len;
		return (stop - held_items() + 1 + wpos) & (STORE_DEPTH - 1);
	endfunction

	// applies one transaction to the shadow buffer and returns its answer
	function automatic reply_t buffer_action(request_t rq);
		reply_t r;
		int unsigned len, a, b, n;
		logic [COUNT_BITS-1:0] diff;
		r = '0;
		len = cur_len();
		if (rq.act == mhrb_pkg::ACT_INSERT) begin
			a = wr_pos & (len - 1);
			b = (a + len) & (2 * len - 1);
			hist_mem[a] = rq.data;
			hist_mem[b] = rq.data;
			hist_written[a] = 1'b1;
			hist_written[b] = 1'b1;
			wr_pos = (a + 1) & (len - 1);
			ins_cnt = ins_cnt + 1;
		end else if (rq.act == mhrb_pkg::ACT_CLEAR) begin
			wr_pos = 0;
			ins_cnt = '0;
		end
		n = held_items();
		if (rq.act == mhrb_pkg::ACT_READ) begin
			if (rq.wpos >= n)
				r.err = 1'b1;
			else
				r.item = hist_mem[window_slot(rq.wpos)];
		end else if (rq.act == mhrb_pkg::ACT_C2P) begin
			diff = ins_cnt - rq.qcnt;
			if (rq.qcnt > ins_cnt || diff >= n)
				r.err = 1'b1;
			else
				r.pos = MAX_LG'(n - diff - 1);
		end else if (rq.act == mhrb_pkg::ACT_P2C) begin
			if (rq.wpos >= n)
				r.err = 1'b1;
			else
				r.cnt = ins_cnt - COUNT_BITS'(n - 1 - rq.wpos);
		end
		r.wlen = (MAX_LG + 1)'(n);
		r.total = ins_cnt;
		return r;
	endfunction

	function automatic request_t mk(logic [ACTION_BITS-1:0] act, logic [IB-1:0] data,
			logic [MAX_LG-1:0] wpos, logic [COUNT_BITS-1:0] qcnt);
		request_t rq;
		rq.act = act;
		rq.data = data;
		rq.wpos = wpos;
		rq.qcnt = qcnt;
		return rq;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(1, 2);
		else if (r < 92)
			return $urandom_range(3, 6);
		return $urandom_range(15, 40);
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int unsigned n, top;
		int r;
		rq = mk(mhrb_pkg::ACT_INSERT, $urandom, MAX_LG'($urandom), {$urandom, $urandom});
		n = held_items();
		top = (n > (1 << MAX_LG) - 1) ? (1 << MAX_LG) - 1 : n;
		r = $urandom_range(0, 99);
		if (r < 42) begin
			rq.act = mhrb_pkg::ACT_INSERT;
		end else if (r < 64 || (r >= 80 && r < 95)) begin
			rq.act = (r < 64) ? mhrb_pkg::ACT_READ : mhrb_pkg::ACT_P2C;
			if ($urandom_range(0, 4) != 0)
				rq.wpos = MAX_LG'($urandom_range(0, top));
		end else if (r < 80) begin
			rq.act = mhrb_pkg::ACT_C2P;
			case ($urandom_range(0, 7))
				6: rq.qcnt = ins_cnt + COUNT_BITS'($urandom_range(1, 3));
				7: ;
				default: rq.qcnt = ins_cnt - COUNT_BITS'($urandom_range(0, n));
			endcase
		end else if (r < 98) begin
			rq.act = mhrb_pkg::ACT_CLEAR;
		end else begin
			rq.act = ACTION_BITS'(mhrb_pkg::ACT_CLEAR + $urandom_range(1, 3));
		end
		return rq;
	endfunction

	task automatic report(string msg);
		fault_count++;
		if (fault_count <= 10)
			$display("%s", msg);
	endtask

	task automatic sender_gap();
		int g;
		g = (no_idle || $urandom_range(0, 1) == 0) ? 0 : pick_gap();
		if (g > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (g - 1) @(negedge clk);
		end
	endtask

	task automatic offer(request_t rq);
		@(negedge clk);
		// a read that would land on a never-written slot becomes a position query
		if (rq.act == mhrb_pkg::ACT_READ && rq.wpos < held_items()
				&& !hist_written[window_slot(rq.wpos)])
			rq.act = mhrb_pkg::ACT_P2C;
		action = rq.act;
		item_in = rq.data;
		window_pos = rq.wpos;
		query_count = rq.qcnt;
		in_valid = 1'b1;
		do @(posedge clk); while (in_ready !== 1'b1);
		answers_due.push_back(buffer_action(rq));
		sender_gap();
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (answers_due.size() != 0) @(posedge clk);
	endtask

	task automatic set_length(logic [CFG_BITS-1:0] v);
		wait_drained();
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_data = v;
		cfg_valid = 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		len_log2 = v;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic test_directed();
		offer(mk(mhrb_pkg::ACT_READ, '0, '0, '0));
		offer(mk(mhrb_pkg::ACT_C2P, '0, '0, '0));
		offer(mk(mhrb_pkg::ACT_P2C, '0, '0, '0));
		offer(mk(mhrb_pkg::ACT_INSERT, '0, '0, '0));
		offer(mk(mhrb_pkg::ACT_INSERT, '1, '1, '1));
		offer(mk(mhrb_pkg::ACT_INSERT, $urandom, '0, '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(0), '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(1), '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(2), '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(3), '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, '1, '0));
		offer(mk(mhrb_pkg::ACT_C2P, '0, '0, COUNT_BITS'(1)));
		offer(mk(mhrb_pkg::ACT_C2P, '0, '0, COUNT_BITS'(3)));
		offer(mk(mhrb_pkg::ACT_C2P, '0, '0, COUNT_BITS'(0)));
		offer(mk(mhrb_pkg::ACT_C2P, '0, '0, COUNT_BITS'(4)));
		offer(mk(mhrb_pkg::ACT_C2P, '0, '0, '1));
		offer(mk(mhrb_pkg::ACT_P2C, '0, MAX_LG'(0), '0));
		offer(mk(mhrb_pkg::ACT_P2C, '0, MAX_LG'(2), '0));
		offer(mk(mhrb_pkg::ACT_P2C, '0, MAX_LG'(3), '0));
		offer(mk(mhrb_pkg::ACT_P2C, '0, '1, '0));
		for (int k = 1; k <= 3; k++)
			offer(mk(ACTION_BITS'(mhrb_pkg::ACT_CLEAR + k), $urandom, MAX_LG'($urandom),
				{$urandom, $urandom}));
		offer(mk(mhrb_pkg::ACT_CLEAR, '0, '0, '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(0), '0));
	endtask

	task automatic test_lengths();
		set_length('0);
		offer(mk(mhrb_pkg::ACT_INSERT, $urandom, '0, '0));
		offer(mk(mhrb_pkg::ACT_INSERT, $urandom, '0, '0));
		offer(mk(mhrb_pkg::ACT_INSERT, $urandom, '0, '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(0), '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(1), '0));
		offer(mk(mhrb_pkg::ACT_C2P, '0, '0, COUNT_BITS'(3)));
		offer(mk(mhrb_pkg::ACT_P2C, '0, MAX_LG'(0), '0));
		// above the built maximum the length saturates
		set_length('1);
		offer(mk(mhrb_pkg::ACT_INSERT, $urandom, '0, '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(0), '0));
		offer(mk(mhrb_pkg::ACT_READ, '0, MAX_LG'(1), '0));
		offer(mk(mhrb_pkg::ACT_P2C, '0, MAX_LG'(1), '0));
		offer(mk(mhrb_pkg::ACT_CLEAR, '0, '0, '0));
	endtask

	task automatic test_backpressure();
		set_length(CFG_BITS'(3));
		no_idle = 1'b1;
		hold_req = 300;
		for (int k = 0; k < 24; k++)
			offer(random_request());
		no_idle = 1'b0;
	endtask

	task automatic test_drain_pause();
		for (int k = 0; k < 20; k++)
			offer(random_request());
		wait_drained();
		for (int k = 0; k < 10; k++)
			offer(random_request());
	endtask

	task automatic test_random();
		logic [CFG_BITS-1:0] lg;
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p == 0)
				lg = '0;
			else if (p == 1)
				lg = '1;
			else if (p == RANDOM_PHASES - 1)
				lg = CFG_BITS'(MAX_LG);
			else if ($urandom_range(0, 3) == 0)
				lg = CFG_BITS'($urandom_range(0, 15));
			else
				lg = CFG_BITS'($urandom_range(1, 6));
			set_length(lg);
			no_idle = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < PHASE_ITEMS; k++)
				offer(random_request());
		end
		no_idle = 1'b0;
	endtask

	// receiver: random ready gaps, plus long holds on request
	initial begin
		int gap;
		gap = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req > 0) begin
				out_ready = 1'b0;
				hold_req--;
			end else if (no_idle) begin
				out_ready = 1'b1;
			end else if (gap > 0) begin
				out_ready = 1'b0;
				gap--;
			end else begin
				out_ready = 1'b1;
				if ($urandom_range(0, 3) == 0)
					gap = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got_reply.item = item_out;
			got_reply.wlen = window_length;
			got_reply.total = total_count;
			got_reply.pos = pos_out;
			got_reply.cnt = count_out;
			got_reply.err = range_error;
			if (answers_due.size() == 0) begin
				report("unexpected result transaction");
			end else begin
				want_reply = answers_due.pop_front();
				if (got_reply !== want_reply)
					report($sformatf({"mismatch: exp item=%h len=%0d total=%0d pos=%0d cnt=%0d",
						" err=%b / got item=%h len=%0d total=%0d pos=%0d cnt=%0d err=%b"},
						want_reply.item, want_reply.wlen, want_reply.total, want_reply.pos,
						want_reply.cnt, want_reply.err, got_reply.item, got_reply.wlen,
						got_reply.total, got_reply.pos, got_reply.cnt, got_reply.err));
			end
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready === 1'b1) || (out_valid === 1'b1 && out_ready)
					|| (cfg_valid && cfg_ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = LEN_LOG2_RESET;
		in_valid = 1'b0;
		action = mhrb_pkg::ACT_INSERT;
		item_in = '0;
		window_pos = '0;
		query_count = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_lengths();
		test_backpressure();
		test_drain_pause();
		test_random();

		wait_drained();
		repeat (10) @(posedge clk);
		if (fault_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/mhrb_pkg.sv
hw/rtl/mhrb_ram.sv
hw/rtl/mirrored_history_ring_buffer.sv
hw/rtl/mhrb_checker.sv
tb/sv/mirrored_history_ring_buffer_tb.sv
